[hw/rtl/smp_pkg.sv]
// Shared types and constants for the stepper microstep positioner.
`default_nettype none

package smp_pkg;

	localparam int FUNC_W    = 2;
	localparam int TARGET_W  = 29;
	localparam int POS_OUT_W = 32;
	localparam int MODE_W    = 3;

	// Command codes
	localparam logic [FUNC_W-1:0] FUNC_TICK  = 2'd0;
	localparam logic [FUNC_W-1:0] FUNC_MOVE  = 2'd1;
	localparam logic [FUNC_W-1:0] FUNC_CLEAR = 2'd2;

	// Microstep mode pin codes, bit 0 is mode pin one
	localparam logic [MODE_W-1:0] MODE_FULL    = 3'b000;
	localparam logic [MODE_W-1:0] MODE_HALF    = 3'b001;
	localparam logic [MODE_W-1:0] MODE_QUARTER = 3'b010;
	localparam logic [MODE_W-1:0] MODE_EIGHTH  = 3'b011;
	localparam logic [MODE_W-1:0] MODE_INIT    = 3'b001;

	typedef struct packed {
		logic                 busy;
		logic [POS_OUT_W-1:0] position;
		logic [MODE_W-1:0]    mode;
		logic                 dir;
		logic                 step;
	} smp_result_t;

endpackage

`default_nettype wire

[hw/rtl/stepper_microstep_positioner.sv]
// Top level: stream handshake, input register and result register around the core.
`default_nettype none

// Step/direction positioner with the position held in eighth steps. Each beat on
// the slave side carries a command in s_tuser (tick, move, clear) and a target in
// whole steps in s_tdata; every command gives exactly one result beat with the pin
// levels, the position and busy. One command is taken every clock cycle unless the master
// side stalls; its result beat is offered from the clock edge after the one that takes
// the command, later only while the master side stalls. The critical path is the tick
// path: one distance subtract, a compare against 8, 4 and 2, and one position add,
// all between the input register and the result register. Commands are applied in
// order, so a tick sees the state left by the command before it.
module stepper_microstep_positioner
	import smp_pkg::*;
#(
	parameter int POSITION_WIDTH = 32
) (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        s_tvalid,
	output logic             s_tready,
	input  wire logic [31:0] s_tdata,  // [28:0] target_steps, [31:29] zero
	input  wire logic [1:0]  s_tuser,  // [1:0] func
	output logic             m_tvalid,
	input  wire logic        m_tready,
	output logic [39:0]      m_tdata   // [0] step_pin, [1] direction_pin,
	                                   // [2] mode_pin_one, [3] mode_pin_two,
	                                   // [4] mode_pin_three, [36:5] position,
	                                   // [37] busy_res, [39:38] zero
);

	logic                s1_valid_q;
	logic [FUNC_W-1:0]   func_s1;
	logic [TARGET_W-1:0] target_s1;
	logic                out_valid_q;
	smp_result_t         out_q;
	smp_result_t         core_result;
	logic                advance;
	logic                fire;

	assign advance  = !out_valid_q || m_tready;
	assign fire     = s1_valid_q && advance;
	assign s_tready = !s1_valid_q || advance;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			s1_valid_q <= 1'b0;
		end else if (s_tready) begin
			s1_valid_q <= s_tvalid;
		end
	end

	always_ff @(posedge clk) begin
		if (s_tready && s_tvalid) begin
			func_s1   <= s_tuser;
			target_s1 <= s_tdata[TARGET_W-1:0];
		end
	end

	smp_core #(
		.POSITION_WIDTH(POSITION_WIDTH)
	) u_core (
		.clk         (clk),
		.arst_n      (arst_n),
		.en          (fire),
		.func        (func_s1),
		.target_steps(target_s1),
		.result      (core_result)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (advance) begin
			out_valid_q <= s1_valid_q;
		end
	end

	always_ff @(posedge clk) begin
		if (fire) begin
			out_q <= core_result;
		end
	end

	assign m_tvalid = out_valid_q;
	assign m_tdata  = {2'b00, out_q};

`ifndef SYNTHESIS
	a_s1_not_lost: assert property (@(posedge clk) disable iff (!arst_n)
		(s_tvalid && s_tready && s1_valid_q) |-> fire)
		else $error("held command overwritten before it was applied");

	a_result_follows_fire: assert property (@(posedge clk) disable iff (!arst_n)
		fire |=> out_valid_q)
		else $error("applied command gave no result beat");

	a_result_not_lost: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid_q && !m_tready) |=> (out_valid_q && $stable(out_q)))
		else $error("stalled result beat dropped or changed");
`endif

endmodule

`default_nettype wire

[hw/rtl/smp_core.sv]
// Positioner state and the combinational command/step update logic.
`default_nettype none

module smp_core
	import smp_pkg::*;
#(
	parameter int POSITION_WIDTH = 32
) (
	input  wire logic                clk,
	input  wire logic                arst_n,
	input  wire logic                en,
	input  wire logic [FUNC_W-1:0]   func,
	input  wire logic [TARGET_W-1:0] target_steps,
	output smp_result_t              result
);

	logic [POSITION_WIDTH-1:0] pos_q, pos_n;
	logic [POSITION_WIDTH-1:0] goal_q, goal_n;
	logic                      moving_q, moving_n;
	logic                      step_q, step_n;
	logic                      dir_q, dir_n;
	logic [MODE_W-1:0]         mode_q, mode_n;

	logic [POSITION_WIDTH-1:0] goal_new;
	logic [POSITION_WIDTH-1:0] span;
	logic [POSITION_WIDTH-1:0] size;
	logic [MODE_W-1:0]         mode_sel;
	logic [POSITION_WIDTH-1:0] pos_stepped;
	logic                      down;

	assign goal_new = POSITION_WIDTH'({target_steps, 3'b000});
	assign down     = pos_q > goal_q;
	assign span     = down ? (pos_q - goal_q) : (goal_q - pos_q);

	always_comb begin
		if (span[POSITION_WIDTH-1:1] == '0) begin
			size     = POSITION_WIDTH'(1);
			mode_sel = MODE_EIGHTH;
		end else if (span[POSITION_WIDTH-1:2] == '0) begin
			size     = POSITION_WIDTH'(2);
			mode_sel = MODE_QUARTER;
		end else if (span[POSITION_WIDTH-1:3] == '0) begin
			size     = POSITION_WIDTH'(4);
			mode_sel = MODE_HALF;
		end else begin
			size     = POSITION_WIDTH'(8);
			mode_sel = MODE_FULL;
		end
	end

	assign pos_stepped = down ? (pos_q - size) : (pos_q + size);

	always_comb begin
		pos_n    = pos_q;
		goal_n   = goal_q;
		moving_n = moving_q;
		step_n   = step_q;
		dir_n    = dir_q;
		mode_n   = mode_q;
		if (en) begin
			case (func)
				FUNC_TICK: begin
					if (moving_q && (pos_q != goal_q)) begin
						mode_n   = mode_sel;
						step_n   = ~step_q;
						pos_n    = pos_stepped;
						moving_n = pos_stepped != goal_q;
					end else begin
						moving_n = 1'b0;
					end
				end
				FUNC_MOVE: begin
					goal_n = goal_new;
					if (pos_q < goal_new) begin
						dir_n    = 1'b0;
						moving_n = 1'b1;
					end else if (pos_q > goal_new) begin
						dir_n    = 1'b1;
						moving_n = 1'b1;
					end else begin
						moving_n = 1'b0;
					end
				end
				FUNC_CLEAR: begin
					pos_n    = '0;
					moving_n = 1'b0;
				end
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pos_q    <= '0;
			goal_q   <= '0;
			moving_q <= 1'b0;
			step_q   <= 1'b0;
			dir_q    <= 1'b1;
			mode_q   <= MODE_INIT;
		end else begin
			pos_q    <= pos_n;
			goal_q   <= goal_n;
			moving_q <= moving_n;
			step_q   <= step_n;
			dir_q    <= dir_n;
			mode_q   <= mode_n;
		end
	end

	assign result.step     = step_n;
	assign result.dir      = dir_n;
	assign result.mode     = mode_n;
	assign result.position = POS_OUT_W'(pos_n);
	assign result.busy     = moving_n;

`ifndef SYNTHESIS
	a_moving_not_arrived: assert property (@(posedge clk) disable iff (!arst_n)
		moving_q |-> (pos_q != goal_q))
		else $error("move active with position already at goal");

	a_no_overshoot: assert property (@(posedge clk) disable iff (!arst_n)
		moving_q |-> ((dir_q && (pos_q > goal_q)) || (!dir_q && (pos_q < goal_q))))
		else $error("position on wrong side of goal for direction");

	a_step_only_on_tick: assert property (@(posedge clk) disable iff (!arst_n)
		(step_q != $past(step_q)) |-> $past(en && (func == FUNC_TICK) && moving_q))
		else $error("step level changed without a tick during a move");

	a_mode_three_low: assert property (@(posedge clk) disable iff (!arst_n)
		(mode_q != $past(mode_q)) |-> !mode_q[2])
		else $error("mode pin three set by a step");
`endif

endmodule

`default_nettype wire
